### hw/rtl/amd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amd_pkg: motion detector shared types and constants
// Payload structs, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package amd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int AXIS_W          = 16;
    localparam int TIME_W          = 32;
    localparam int HOLD_W          = 31;
    localparam int THR_W           = 16;
    localparam int THR_SQ_W        = 2 * THR_W;
    localparam int CHANGE_W        = 36;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = HOLD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 1'b1;

    localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd1638;
    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET    = 32'd2683044;

    typedef struct packed {
        logic                     sample_ready;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic [TIME_W-1:0]        now_ms;
    } amd_in_t;

    typedef struct packed {
        logic                motion_active;
        logic                motion_changed;
        logic [CHANGE_W-1:0] change_squared;
    } amd_out_t;

    // Between the delta stage and the decision stage.
    typedef struct packed {
        logic                formed;
        logic [CHANGE_W-1:0] change;
        logic [TIME_W-1:0]   now_ms;
    } amd_delta_t;

endpackage
`default_nettype wire

### hw/rtl/amd_delta.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amd_delta: input register and squared-change stage
// Holds the previous sample and forms dx^2+dy^2+dz^2 per ready sample.
// ----------------------------------------------------------------------------
module amd_delta
    import amd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire amd_in_t    item,
    output logic            delta_valid,
    input  wire logic       delta_ready,
    output amd_delta_t      delta
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + 1;
    localparam int SUM_W  = SQ_W + 2;

    logic                          in_valid_reg;
    amd_in_t                       in_reg;
    logic signed [SAMPLE_BITS-1:0] prev_x_reg;
    logic signed [SAMPLE_BITS-1:0] prev_y_reg;
    logic signed [SAMPLE_BITS-1:0] prev_z_reg;
    logic                          baseline_reg;
    logic                          delta_valid_reg;
    amd_delta_t                    delta_reg;
    amd_delta_t                    delta_next;

    logic signed [SAMPLE_BITS-1:0] x_s;
    logic signed [SAMPLE_BITS-1:0] y_s;
    logic signed [SAMPLE_BITS-1:0] z_s;
    logic signed [DIFF_W-1:0]      dx;
    logic signed [DIFF_W-1:0]      dy;
    logic signed [DIFF_W-1:0]      dz;
    logic signed [PROD_W-1:0]      px;
    logic signed [PROD_W-1:0]      py;
    logic signed [PROD_W-1:0]      pz;
    logic [SUM_W-1:0]              sum;
    logic                          formed;
    logic                          advance;

    assign advance    = in_valid_reg && (!delta_valid_reg || delta_ready);
    assign item_ready = !in_valid_reg || advance;

    assign x_s = in_reg.accel_x[SAMPLE_BITS-1:0];
    assign y_s = in_reg.accel_y[SAMPLE_BITS-1:0];
    assign z_s = in_reg.accel_z[SAMPLE_BITS-1:0];

    assign dx = {x_s[SAMPLE_BITS-1], x_s} - {prev_x_reg[SAMPLE_BITS-1], prev_x_reg};
    assign dy = {y_s[SAMPLE_BITS-1], y_s} - {prev_y_reg[SAMPLE_BITS-1], prev_y_reg};
    assign dz = {z_s[SAMPLE_BITS-1], z_s} - {prev_z_reg[SAMPLE_BITS-1], prev_z_reg};

    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    assign sum = SUM_W'(px[SQ_W-1:0]) + SUM_W'(py[SQ_W-1:0]) + SUM_W'(pz[SQ_W-1:0]);

    assign formed = in_reg.sample_ready && baseline_reg;

    always_comb
    begin
        delta_next.formed = formed;
        delta_next.change = formed ? CHANGE_W'(sum) : '0;
        delta_next.now_ms = in_reg.now_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            delta_valid_reg <= 1'b0;
            baseline_reg    <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_z_reg      <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (!delta_valid_reg || delta_ready)
            begin
                delta_valid_reg <= in_valid_reg;
            end
            if (advance && in_reg.sample_ready)
            begin
                baseline_reg <= 1'b1;
                prev_x_reg   <= x_s;
                prev_y_reg   <= y_s;
                prev_z_reg   <= z_s;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            delta_reg <= delta_next;
        end
    end

    assign delta_valid = delta_valid_reg;
    assign delta       = delta_reg;

endmodule
`default_nettype wire

### hw/rtl/accel_motion_detector_with_hold_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a result passes three register stages (input, delta, result) after its input transfer.
// Throughput: one item per cycle while result_ready is high; the result register is the only point of backpressure.
// Reset (async, active low) clears all valid flags, the baseline, the motion state and
// the release time; the squared threshold returns to 1638^2 and the hold time to 0.
// ----------------------------------------------------------------------------
// accel_motion_detector_with_hold_unit: motion detector with hold time
// Squared change against squared threshold, hold release on 32-bit wrap.
// ----------------------------------------------------------------------------
module accel_motion_detector_with_hold_unit
    import amd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire amd_in_t               item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output amd_out_t                   result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic                delta_valid;
    logic                delta_ready;
    amd_delta_t          delta;

    logic [THR_SQ_W-1:0] thr_sq_reg;
    logic [THR_SQ_W-1:0] thr_sq_next;
    logic [HOLD_W-1:0]   hold_reg;
    logic                motion_reg;
    logic                motion_next;
    logic [TIME_W-1:0]   release_reg;
    logic [TIME_W-1:0]   release_next;
    logic [TIME_W-1:0]   since;
    logic                over;
    logic                take;
    logic                result_valid_reg;
    amd_out_t            result_reg;
    amd_out_t            result_next;

    amd_delta #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_delta (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .delta_valid (delta_valid),
        .delta_ready (delta_ready),
        .delta       (delta)
    );

    assign thr_sq_next = THR_SQ_W'(cfg_data[THR_W-1:0]) * THR_SQ_W'(cfg_data[THR_W-1:0]);

    assign delta_ready = !result_valid_reg || result_ready;
    assign take        = delta_valid && delta_ready;

    assign over         = delta.change > CHANGE_W'(thr_sq_reg);
    assign since        = delta.now_ms - release_reg;
    assign release_next = delta.now_ms + TIME_W'(hold_reg);

    always_comb
    begin
        motion_next = motion_reg;
        if (delta.formed)
        begin
            if (over)
            begin
                motion_next = 1'b1;
            end
            else if (motion_reg && !since[TIME_W-1])
            begin
                motion_next = 1'b0;
            end
        end
        result_next.motion_active  = motion_next;
        result_next.motion_changed = motion_next != motion_reg;
        result_next.change_squared = delta.change;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_sq_reg       <= THR_SQ_RESET;
            hold_reg         <= '0;
            motion_reg       <= 1'b0;
            release_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESHOLD: thr_sq_reg <= thr_sq_next;
                    CFG_HOLD:      hold_reg   <= cfg_data[HOLD_W-1:0];
                    default:       ;
                endcase
            end
            if (delta_ready)
            begin
                result_valid_reg <= delta_valid;
            end
            if (take)
            begin
                motion_reg <= motion_next;
                if (delta.formed && over)
                begin
                    release_reg <= release_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

### hw/rtl/amd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amd_checker: port-level checks for the motion detector
// Watches transfers on both channels and the reported motion sequence.
// ----------------------------------------------------------------------------
module amd_checker
    import amd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire logic                  item_ready,
    input  wire logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire amd_out_t              result
);

    logic [2:0] pending_reg;
    logic       last_active_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = item_valid && item_ready;
    assign out_xfer = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            last_active_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_xfer) - 3'(out_xfer);
            if (out_xfer)
            begin
                last_active_reg <= result.motion_active;
            end
        end
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result_valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result without an outstanding transfer");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.motion_changed == (result.motion_active != last_active_reg))
        else $error("motion_changed disagrees with motion sequence");

    a_change_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.change_squared[CHANGE_W-1:CHANGE_W-2] == 2'b00)
        else $error("change_squared out of range");

endmodule

bind accel_motion_detector_with_hold_unit amd_checker u_amd_checker (.*);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: motion detector with hold time
// Drives accelerometer samples over valid/ready with random gaps and stalls
// and sets the threshold and hold registers between phases. A scoreboard
// predicts each report (change energy, motion state, toggle) and checks the
// reports in order.
// ----------------------------------------------------------------------------
module testbench;
    import amd_pkg::*;

    localparam int RX_HOLD_CYCLES = 120;
    localparam int DRAIN_PAD      = 6;

    class motion_checker;
        logic [THR_W-1:0]         thr;
        logic [HOLD_W-1:0]        hold_ms;
        logic signed [AXIS_W-1:0] last_x;
        logic signed [AXIS_W-1:0] last_y;
        logic signed [AXIS_W-1:0] last_z;
        bit                       have_base;
        bit                       moving;
        logic [TIME_W-1:0]        release_at;
        amd_out_t                 awaited_reports[$];
        int                       errors;

        function new();
            thr        = THRESHOLD_RESET;
            hold_ms    = '0;
            last_x     = '0;
            last_y     = '0;
            last_z     = '0;
            have_base  = 1'b0;
            moving     = 1'b0;
            release_at = '0;
            errors     = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_THRESHOLD)
                thr = data[THR_W-1:0];
            else if (idx == CFG_HOLD)
                hold_ms = data[HOLD_W-1:0];
        endfunction

        function void take_sample(input amd_in_t it);
            amd_out_t          want;
            longint            dx;
            longint            dy;
            longint            dz;
            longint            energy;
            longint            thr_sq;
            logic [TIME_W-1:0] since;
            bit                was_moving;
            was_moving = moving;
            energy     = 0;
            if (it.sample_ready)
            begin
                if (!have_base)
                    have_base = 1'b1;
                else
                begin
                    dx     = longint'(it.accel_x) - longint'(last_x);
                    dy     = longint'(it.accel_y) - longint'(last_y);
                    dz     = longint'(it.accel_z) - longint'(last_z);
                    energy = dx * dx + dy * dy + dz * dz;
                    thr_sq = longint'(thr) * longint'(thr);
                    since  = it.now_ms - release_at;
                    if (energy > thr_sq)
                    begin
                        release_at = it.now_ms + TIME_W'(hold_ms);
                        moving     = 1'b1;
                    end
                    else if (moving && !since[TIME_W-1])
                        moving = 1'b0;
                end
                last_x = it.accel_x;
                last_y = it.accel_y;
                last_z = it.accel_z;
            end
            want.motion_active  = moving;
            want.motion_changed = (moving != was_moving);
            want.change_squared = energy[CHANGE_W-1:0];
            awaited_reports.push_back(want);
        endfunction

        function void check_report(input amd_out_t got);
            amd_out_t want;
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: unexpected report act=%0d/%0d/%0d", $time,
                         got.motion_active, got.motion_changed, got.change_squared);
                errors++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (got.motion_active !== want.motion_active ||
                    got.motion_changed !== want.motion_changed ||
                    got.change_squared !== want.change_squared)
                begin
                    $display("%0t: mismatch active/changed/energy exp=%0d/%0d/%0d act=%0d/%0d/%0d",
                             $time, want.motion_active, want.motion_changed,
                             want.change_squared, got.motion_active,
                             got.motion_changed, got.change_squared);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    amd_in_t               item;
    logic                  result_valid;
    logic                  result_ready;
    amd_out_t              result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    motion_checker            sb;
    int                       tx_idle_pct;
    int                       rx_idle_pct;
    bit                       rx_hold_go;
    int                       rx_hold_cnt;
    logic signed [AXIS_W-1:0] cur_x;
    logic signed [AXIS_W-1:0] cur_y;
    logic signed [AXIS_W-1:0] cur_z;
    logic [TIME_W-1:0]        cur_now;

    accel_motion_detector_with_hold_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.take_sample(item);
            if (result_valid && result_ready)
                sb.check_report(result);
        end
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        result_ready = 1'b0;
        rx_hold_cnt  = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_go && rx_hold_cnt < RX_HOLD_CYCLES)
            begin
                result_ready <= 1'b0;
                rx_hold_cnt++;
            end
            else
                result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic amd_in_t mk_item(input bit rdy, input int x, input int y,
                                        input int z, input logic [TIME_W-1:0] now);
        amd_in_t it;
        it.sample_ready = rdy;
        it.accel_x      = AXIS_W'(x);
        it.accel_y      = AXIS_W'(y);
        it.accel_z      = AXIS_W'(z);
        it.now_ms       = now;
        return it;
    endfunction

    function automatic logic signed [AXIS_W-1:0] wobble(input logic signed [AXIS_W-1:0] v,
                                                        input int span);
        int d;
        d = int'($urandom_range(2 * span)) - span;
        return AXIS_W'(int'(v) + d);
    endfunction

    task automatic send_item(input amd_in_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_regs(input logic [THR_W-1:0] thr, input logic [HOLD_W-1:0] hold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(thr);
        @(posedge clk);
        sb.set_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_index <= CFG_HOLD;
        cfg_data  <= hold;
        @(posedge clk);
        sb.set_reg(CFG_HOLD, hold);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n_ready, input int span_small);
        amd_in_t it;
        int      done;
        int      span;
        done = 0;
        while (done < n_ready)
        begin
            it.sample_ready = ($urandom_range(9) != 0);
            if ($urandom_range(9) == 0)
            begin
                it.accel_x = AXIS_W'($urandom);
                it.accel_y = AXIS_W'($urandom);
                it.accel_z = AXIS_W'($urandom);
            end
            else
            begin
                span       = ($urandom_range(4) == 0) ? 40000 : span_small;
                it.accel_x = wobble(cur_x, span);
                it.accel_y = wobble(cur_y, span);
                it.accel_z = wobble(cur_z, span);
            end
            if ($urandom_range(19) == 0)
                cur_now = $urandom;
            else
                cur_now = cur_now + TIME_W'($urandom_range(60));
            it.now_ms = cur_now;
            if (it.sample_ready)
            begin
                cur_x = it.accel_x;
                cur_y = it.accel_y;
                cur_z = it.accel_z;
                done++;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_THRESHOLD;
        cfg_data    = '0;
        tx_idle_pct = 18;
        rx_idle_pct = 46;
        rx_hold_go  = 1'b0;
        cur_x       = '0;
        cur_y       = '0;
        cur_z       = '0;
        cur_now     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: ignored item, baseline, full-scale swing, release at hold 0
        send_item(mk_item(1'b0, -32768, 32767, -1, 32'hFFFF_FFFF));
        send_item(mk_item(1'b1, -32768, -32768, -32768, 32'd0));
        send_item(mk_item(1'b1, 32767, 32767, 32767, 32'd100));
        send_item(mk_item(1'b0, 12345, -9876, 0, 32'h5555_AAAA));
        send_item(mk_item(1'b1, 32767, 32767, 32767, 32'd100));
        drain();

        // threshold boundary, motion onset, release exactly at deadline
        write_regs(16'd1000, 31'd50);
        send_item(mk_item(1'b1, 0, 0, 0, 32'd1000));
        send_item(mk_item(1'b1, 1000, 0, 0, 32'd1010));
        send_item(mk_item(1'b1, 1000, 0, 0, 32'd1049));
        send_item(mk_item(1'b1, -1, 0, 0, 32'd1060));
        send_item(mk_item(1'b1, -1, 0, 0, 32'd1109));
        send_item(mk_item(1'b1, -1, 0, 0, 32'd1110));
        drain();

        // zero threshold, longest hold, timestamps across the wrap
        write_regs(16'd0, 31'h7FFF_FFFF);
        send_item(mk_item(1'b1, 0, 0, 0, 32'hFFFF_FF00));
        send_item(mk_item(1'b1, 0, 0, 0, 32'h7FFF_FEFE));
        send_item(mk_item(1'b1, 0, 0, 0, 32'h7FFF_FEFF));
        send_item(mk_item(1'b1, 32767, -32768, 1, 32'h8000_0000));
        drain();

        // largest threshold
        write_regs(16'hFFFF, 31'd0);
        send_item(mk_item(1'b1, -32768, -32768, -32768, 32'd5));
        send_item(mk_item(1'b1, 32767, 32767, 32767, 32'd6));
        send_item(mk_item(1'b0, -1, -1, -1, 32'd7));
        send_item(mk_item(1'b1, 32767, 32767, 32767, 32'd6));
        send_item(mk_item(1'b1, 0, 0, 0, 32'd6));
        drain();
        cur_now = 32'd6;

        write_regs(THR_W'($urandom_range(500, 3000)), HOLD_W'($urandom_range(300)));
        run_random(585, 1200);
        drain();

        tx_idle_pct = 46;
        rx_idle_pct <= 18;
        write_regs(16'hFFFF, 31'h7FFF_FFFF);
        run_random(585, 30000);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        rx_hold_go  <= 1'b1;
        write_regs(16'd0, 31'd0);
        run_random(585, 3);
        drain();

        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
